// ===== rtl/core/rgm_pkg.sv =====
// Shared constants, types and a helper function of the horizontal grid ray march.
package rgm_pkg;

    localparam int BLOCK_SIZE_DEF = 64;
    localparam int MAP_SIDE_DEF   = 64;

    localparam int DIR_W  = 16;
    localparam int FRAC_W = 16;
    localparam int DIST_W = 23;
    localparam int ROW_W  = 14;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAX_STEPS  = 2'd2;

    localparam logic [6:0] MAP_WIDTH_RST  = 7'd64;
    localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;
    localparam logic [7:0] MAX_STEPS_RST  = 8'd32;

    typedef struct packed {
        logic       write;
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       init;
        logic       probe;
        logic       advance;
        logic       sq_a;
        logic       sq_b;
        logic       sqrt_start;
        logic       out_hit;
        logic       out_miss;
    } t_cmd;

    typedef struct packed {
        logic dy_zero;
        logic div_busy;
        logic cont;
        logic wall;
        logic sqrt_busy;
        logic out_full;
    } t_sts;

    function automatic logic [DIST_W-1:0] miss_dist(logic [7:0] max_steps, int block_size);
        logic [31:0] d;
        d = (32'(max_steps) + 32'd1) * 32'(block_size) * 32'd256;
        return (d > 32'(DIST_MAX)) ? DIST_MAX : d[DIST_W-1:0];
    endfunction

endpackage

// ===== rtl/core/rgm_if.sv =====
// Valid/ready channel interfaces for input and result items.
interface rgm_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [5:0]         cell_col;
    logic [5:0]         cell_row;
    logic               cell_is_wall;
    logic [11:0]        player_x;
    logic [11:0]        player_y;
    logic signed [6:0]  player_z;
    logic signed [15:0] ray_dx;
    logic signed [15:0] ray_dy;
    logic signed [15:0] ray_dz;

    modport source (output valid, op, cell_col, cell_row, cell_is_wall, player_x, player_y,
                    player_z, ray_dx, ray_dy, ray_dz, input ready);
    modport sink (input valid, op, cell_col, cell_row, cell_is_wall, player_x, player_y,
                  player_z, ray_dx, ray_dy, ray_dz, output ready);
endinterface

interface rgm_out_if;
    logic        valid;
    logic        ready;
    logic [22:0] hit_distance;
    logic        wall_hit;

    modport source (output valid, hit_distance, wall_hit, input ready);
    modport sink (input valid, hit_distance, wall_hit, output ready);
endinterface

// ===== rtl/core/rgm_ctrl.sv =====
// Controller state machine sequencing setup, division, march, root and result.
module rgm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_op,
    output logic          o_in_ready,
    input  rgm_pkg::t_sts i_sts,
    output rgm_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_DIV, S_INIT, S_CHECK, S_PROBE,
        S_SQA, S_SQB, S_SQS, S_SQRT, S_HIT, S_MISS
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_div_n, n_div_n;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_div_n = r_div_n;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == rgm_pkg::OP_CAST) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SETUP;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_SETUP: begin
                if (i_sts.dy_zero) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = 2'd0;
                    n_div_n         = 2'd0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    if (r_div_n == 2'd3) begin
                        n_state = S_INIT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = r_div_n + 2'd1;
                        n_div_n         = r_div_n + 2'd1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.cont) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_PROBE;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_PROBE: begin
                if (i_sts.wall) begin
                    n_state = S_SQA;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_SQA: begin
                o_cmd.sq_a = 1'b1;
                n_state    = S_SQB;
            end
            S_SQB: begin
                o_cmd.sq_b = 1'b1;
                n_state    = S_SQS;
            end
            S_SQS: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_SQRT;
            end
            S_SQRT: begin
                if (!i_sts.sqrt_busy) begin
                    n_state = S_HIT;
                end
            end
            S_HIT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_hit = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MISS: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_miss = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_div_n <= 2'd0;
        end else begin
            r_state <= n_state;
            r_div_n <= n_div_n;
        end
    end

endmodule

// ===== rtl/core/rgm_dp.sv =====
// Datapath: wall map, shared divider, march registers, square root and result register.
module rgm_dp #(
    parameter int BLOCK_SIZE = rgm_pkg::BLOCK_SIZE_DEF,
    parameter int MAP_SIDE   = rgm_pkg::MAP_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rgm_pkg::t_cmd               i_cmd,
    output rgm_pkg::t_sts               o_sts,
    input  logic [5:0]                  i_cell_col,
    input  logic [5:0]                  i_cell_row,
    input  logic                        i_cell_is_wall,
    input  logic [11:0]                 i_player_x,
    input  logic [11:0]                 i_player_y,
    input  logic signed [6:0]           i_player_z,
    input  logic signed [15:0]          i_ray_dx,
    input  logic signed [15:0]          i_ray_dy,
    input  logic signed [15:0]          i_ray_dz,
    input  logic [6:0]                  i_map_width,
    input  logic [6:0]                  i_map_height,
    input  logic [7:0]                  i_max_steps,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [rgm_pkg::DIST_W-1:0]  o_hit_distance,
    output logic                        o_wall_hit
);

    localparam int DW     = rgm_pkg::DIR_W;
    localparam int DF_W   = $clog2(BLOCK_SIZE + 1);
    localparam int PR_W   = DW + DF_W;
    localparam int NUM_W  = PR_W + rgm_pkg::FRAC_W;
    localparam int POS_W  = NUM_W + 2;
    localparam int XL_W   = 7 + $clog2(BLOCK_SIZE) + rgm_pkg::FRAC_W;
    localparam int XI_W   = XL_W - rgm_pkg::FRAC_W;
    localparam int OX_W   = (XL_W > 28) ? XL_W : 28;
    localparam int AX_W   = OX_W - 8;
    localparam int AY_W   = $clog2(BLOCK_SIZE * 257 + 1);
    localparam int AYS_W  = AY_W + 8;
    localparam int HALF_W = ((AX_W > AYS_W) ? AX_W : AYS_W) + 1;
    localparam int SUM_W  = 2 * HALF_W;
    localparam int DC_W   = $clog2(NUM_W + 1);
    localparam int SC_W   = $clog2(HALF_W + 1);
    localparam int AW     = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int RW     = rgm_pkg::ROW_W;
    localparam longint HALF_Z = longint'(BLOCK_SIZE / 2) * 65536;

    // wall map
    logic r_mem [MAP_SIDE*MAP_SIDE];
    logic r_rd, r_probe_ok;

    // item registers
    logic [11:0]          r_px;
    logic signed [6:0]    r_pz;
    logic [DW-1:0]        r_dx_mag, r_dz_mag, r_ady;
    logic                 r_dx_neg, r_dz_neg, r_dy_neg;
    logic [DF_W-1:0]      r_dfirst;

    // divider
    logic [NUM_W-1:0]     r_div_num, r_div_q;
    logic [DW:0]          r_div_rem;
    logic [DC_W-1:0]      r_div_cnt;
    logic                 r_div_busy;
    logic [1:0]           r_div_sel;
    logic [NUM_W-1:0]     r_qm [4];

    // march
    logic signed [POS_W-1:0] r_x, r_z;
    logic signed [RW-1:0]    r_row;
    logic [AY_W-1:0]         r_ay;
    logic [7:0]              r_steps;

    // distance
    logic [SUM_W-1:0]     r_sq;
    logic [SUM_W-1:0]     r_sq_rad;
    logic [HALF_W+1:0]    r_sq_rem;
    logic [HALF_W-1:0]    r_sq_root;
    logic [SC_W-1:0]      r_sq_cnt;
    logic                 r_sq_busy;

    // result
    logic                       r_out_valid;
    logic [rgm_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_hit;

    // load terms
    logic [DW-1:0]    l_ady, l_dxm, l_dzm;
    logic [DF_W-1:0]  l_rem, l_dfirst;
    logic [11:0]      l_quo;
    logic signed [RW-1:0] l_row;

    always_comb begin
        l_ady    = i_ray_dy[15] ? (~i_ray_dy + 16'd1) : i_ray_dy;
        l_dxm    = i_ray_dx[15] ? (~i_ray_dx + 16'd1) : i_ray_dx;
        l_dzm    = i_ray_dz[15] ? (~i_ray_dz + 16'd1) : i_ray_dz;
        l_rem    = DF_W'(i_player_y % BLOCK_SIZE);
        l_quo    = 12'(i_player_y / BLOCK_SIZE);
        l_dfirst = i_ray_dy[15] ? l_rem : (DF_W'(BLOCK_SIZE) - l_rem);
        l_row    = $signed(RW'(l_quo)) + (i_ray_dy[15] ? -RW'(1) : RW'(1));
    end

    // divider operands and one restoring step
    logic [DW-1:0]    l_mag;
    logic [DF_W-1:0]  l_mult;
    logic [PR_W-1:0]  l_prod;
    logic [DW:0]      l_trial;
    logic             l_qbit;
    logic [NUM_W-1:0] l_q_next;

    always_comb begin
        l_mag    = i_cmd.div_sel[0] ? r_dz_mag : r_dx_mag;
        l_mult   = i_cmd.div_sel[1] ? DF_W'(BLOCK_SIZE) : r_dfirst;
        l_prod   = PR_W'(l_mag) * PR_W'(l_mult);
        l_trial  = {r_div_rem[DW-1:0], r_div_num[NUM_W-1]};
        l_qbit   = (l_trial >= {1'b0, r_ady});
        l_q_next = {r_div_q[NUM_W-2:0], l_qbit};
    end

    // signed increments and march tests
    logic signed [POS_W-1:0] l_q0, l_q1, l_sx, l_sz, l_px16, l_pz16, l_zz, l_xlim;
    logic [XI_W-1:0]         l_mx;
    logic                    l_in_map;
    logic [AW-1:0]           l_rd_addr, l_wr_addr;

    always_comb begin
        l_q0   = r_dx_neg ? -$signed({2'b00, r_qm[0]}) : $signed({2'b00, r_qm[0]});
        l_q1   = r_dz_neg ? -$signed({2'b00, r_qm[1]}) : $signed({2'b00, r_qm[1]});
        l_sx   = r_dx_neg ? -$signed({2'b00, r_qm[2]}) : $signed({2'b00, r_qm[2]});
        l_sz   = r_dz_neg ? -$signed({2'b00, r_qm[3]}) : $signed({2'b00, r_qm[3]});
        l_px16 = $signed(POS_W'({r_px, 16'h0000}));
        l_pz16 = $signed({{(POS_W - 23){r_pz[6]}}, r_pz, 16'h0000});
        l_zz   = r_z + l_pz16;
        l_xlim = $signed(POS_W'({32'(i_map_width) * 32'(BLOCK_SIZE), 16'h0000}));
        l_mx   = XI_W'(r_x[XL_W-1:rgm_pkg::FRAC_W] / BLOCK_SIZE);
        l_in_map = (r_row >= 0) && (r_row < $signed(RW'(i_map_height)))
                   && (r_row < RW'(MAP_SIDE)) && (32'(l_mx) < MAP_SIDE);
        l_rd_addr = AW'(32'(r_row[RW-2:0]) * MAP_SIDE + 32'(l_mx));
        l_wr_addr = AW'(32'(i_cell_row) * MAP_SIDE + 32'(i_cell_col));
    end

    // distance operands
    logic signed [POS_W-1:0] l_ox;
    logic [POS_W-1:0]        l_oxm;
    logic [HALF_W-1:0]       l_ax, l_ays;
    logic [HALF_W+3:0]       l_sq_rem2, l_sq_trial;
    logic                    l_sq_ge;

    always_comb begin
        l_ox       = r_x - l_px16;
        l_oxm      = l_ox[POS_W-1] ? POS_W'(-l_ox) : POS_W'(l_ox);
        l_ax       = HALF_W'(AX_W'(l_oxm >> 8));
        l_ays      = HALF_W'({r_ay, 8'h00});
        l_sq_rem2  = {r_sq_rem, r_sq_rad[SUM_W-1:SUM_W-2]};
        l_sq_trial = (HALF_W + 4)'({r_sq_root, 2'b01});
        l_sq_ge    = (l_sq_rem2 >= l_sq_trial);
    end

    // map write and probe
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (32'(i_cell_col) < MAP_SIDE) && (32'(i_cell_row) < MAP_SIDE)) begin
            r_mem[l_wr_addr] <= i_cell_is_wall;
        end
        if (i_cmd.probe) begin
            r_rd       <= r_mem[l_rd_addr];
            r_probe_ok <= l_in_map;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px     <= i_player_x;
            r_pz     <= i_player_z;
            r_dx_mag <= l_dxm;
            r_dz_mag <= l_dzm;
            r_ady    <= l_ady;
            r_dx_neg <= i_ray_dx[15];
            r_dz_neg <= i_ray_dz[15];
            r_dy_neg <= i_ray_dy[15];
            r_dfirst <= l_dfirst;
            r_row    <= l_row;
            r_ay     <= AY_W'(l_dfirst);
        end
        if (i_cmd.div_start) begin
            r_div_num <= {l_prod, 16'h0000};
            r_div_rem <= '0;
            r_div_q   <= '0;
            r_div_sel <= i_cmd.div_sel;
        end else if (r_div_busy) begin
            r_div_num <= {r_div_num[NUM_W-2:0], 1'b0};
            r_div_rem <= l_qbit ? (l_trial - {1'b0, r_ady}) : l_trial;
            r_div_q   <= l_q_next;
            if (r_div_cnt == DC_W'(1)) begin
                r_qm[r_div_sel] <= l_q_next;
            end
        end
        if (i_cmd.init) begin
            r_x     <= l_px16 + l_q0;
            r_z     <= l_q1;
            r_steps <= 8'd0;
        end else if (i_cmd.advance) begin
            r_x     <= r_x + l_sx;
            r_z     <= r_z + l_sz;
            r_row   <= r_row + (r_dy_neg ? -RW'(1) : RW'(1));
            r_ay    <= r_ay + AY_W'(BLOCK_SIZE);
            r_steps <= r_steps + 8'd1;
        end
        if (i_cmd.sq_a) begin
            r_sq <= l_ax * l_ax;
        end else if (i_cmd.sq_b) begin
            r_sq <= r_sq + l_ays * l_ays;
        end
        if (i_cmd.sqrt_start) begin
            r_sq_rad  <= r_sq;
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_sq_busy) begin
            r_sq_rad  <= {r_sq_rad[SUM_W-3:0], 2'b00};
            r_sq_rem  <= (HALF_W + 2)'(l_sq_ge ? (l_sq_rem2 - l_sq_trial) : l_sq_rem2);
            r_sq_root <= {r_sq_root[HALF_W-2:0], l_sq_ge};
        end
        if (i_cmd.out_hit) begin
            r_out_dist <= (r_sq_root > HALF_W'(rgm_pkg::DIST_MAX)) ? rgm_pkg::DIST_MAX
                                                                 : rgm_pkg::DIST_W'(r_sq_root);
            r_out_hit  <= 1'b1;
        end else if (i_cmd.out_miss) begin
            r_out_dist <= rgm_pkg::miss_dist(i_max_steps, BLOCK_SIZE);
            r_out_hit  <= 1'b0;
        end
    end

    // control registers of the iterative units and the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy  <= 1'b0;
            r_div_cnt   <= '0;
            r_sq_busy   <= 1'b0;
            r_sq_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DC_W'(NUM_W);
            end else if (r_div_busy) begin
                r_div_cnt  <= r_div_cnt - DC_W'(1);
                r_div_busy <= (r_div_cnt != DC_W'(1));
            end
            if (i_cmd.sqrt_start) begin
                r_sq_busy <= 1'b1;
                r_sq_cnt  <= SC_W'(HALF_W);
            end else if (r_sq_busy) begin
                r_sq_cnt  <= r_sq_cnt - SC_W'(1);
                r_sq_busy <= (r_sq_cnt != SC_W'(1));
            end
            if (i_cmd.out_hit || i_cmd.out_miss) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.dy_zero   = (r_ady == '0);
        o_sts.div_busy  = r_div_busy;
        o_sts.cont      = (r_steps < i_max_steps) && (r_x > 0) && (r_x < l_xlim)
                          && (l_zz <= HALF_Z) && (l_zz >= -HALF_Z);
        o_sts.wall      = r_rd && r_probe_ok;
        o_sts.sqrt_busy = r_sq_busy;
        o_sts.out_full  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit_distance = r_out_dist;
    assign o_wall_hit     = r_out_hit;

endmodule

// ===== rtl/core/grid_ray_horizontal_march.sv =====
// Top level of the horizontal grid ray march: register port, controller and datapath.
//
// Input channel i_in carries items: op write stores one wall-map cell and is done
// in the cycle it is accepted (no result). op cast marches one ray and gives exactly
// one result item on o_out: the distance in unsigned Q15.8 and a wall flag.
// The divider works on NUM_W = 16 + clog2(BLOCK_SIZE+1) + 16 bits (39 at the default
// block size) and the root on HALF_W bits, 24 there. The four per-ray quotients share
// one radix-2 divider, each map probe goes through the single map read port, and the
// distance root runs one bit per cycle. A ray with zero dy skips all of that and
// answers with a miss. One cast is in flight at a time; the input is ready again once
// its result sits in the output register, so the next item is taken while that result
// still waits. A stalled receiver holds the result and, for a following cast, holds
// the controller before its own result.
// Reset clears control state and sets the registers to 64 columns, 64 rows and
// 32 steps. The wall map has no reset; write each cell before a ray can probe it.
// Registers sit on the APB port at byte addresses 0, 4 and 8; pready stays high.
module grid_ray_horizontal_march #(
    parameter int BLOCK_SIZE = rgm_pkg::BLOCK_SIZE_DEF,
    parameter int MAP_SIDE   = rgm_pkg::MAP_SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgm_in_if.sink      i_in,
    rgm_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] r_map_width, r_map_height;
    logic [7:0] r_max_steps;

    rgm_pkg::t_cmd w_cmd;
    rgm_pkg::t_sts w_sts;

    assign pready = 1'b1;

    // register writes land in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= rgm_pkg::MAP_WIDTH_RST;
            r_map_height <= rgm_pkg::MAP_HEIGHT_RST;
            r_max_steps  <= rgm_pkg::MAX_STEPS_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                rgm_pkg::REG_MAP_WIDTH:  r_map_width  <= pwdata[6:0];
                rgm_pkg::REG_MAP_HEIGHT: r_map_height <= pwdata[6:0];
                rgm_pkg::REG_MAX_STEPS:  r_max_steps  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rgm_pkg::REG_MAP_WIDTH:  prdata = 32'(r_map_width);
            rgm_pkg::REG_MAP_HEIGHT: prdata = 32'(r_map_height);
            rgm_pkg::REG_MAX_STEPS:  prdata = 32'(r_max_steps);
            default:                 prdata = 32'd0;
        endcase
    end

    // controller sequences one item at a time
    rgm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath holds the map, the divider, the march and the root unit
    rgm_dp #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .MAP_SIDE   (MAP_SIDE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cell_col     (i_in.cell_col),
        .i_cell_row     (i_in.cell_row),
        .i_cell_is_wall (i_in.cell_is_wall),
        .i_player_x     (i_in.player_x),
        .i_player_y     (i_in.player_y),
        .i_player_z     (i_in.player_z),
        .i_ray_dx       (i_in.ray_dx),
        .i_ray_dy       (i_in.ray_dy),
        .i_ray_dz       (i_in.ray_dz),
        .i_map_width    (r_map_width),
        .i_map_height   (r_map_height),
        .i_max_steps    (r_max_steps),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_hit_distance (o_out.hit_distance),
        .o_wall_hit     (o_out.wall_hit)
    );

    // a cast item blocks the input on the next cycle
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && (i_in.op == rgm_pkg::OP_CAST) |=> !i_in.ready)
        else $error("input still ready after a cast item");

    // a miss always reports the miss distance
    a_miss_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.wall_hit
            |-> o_out.hit_distance == rgm_pkg::miss_dist(r_max_steps, BLOCK_SIZE))
        else $error("miss result with wrong distance");

    // a new result only comes out of a busy controller
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> !$past(i_in.ready))
        else $error("result appeared while idle");

endmodule

// ===== tb/ray_march_checker.sv =====
// Checker of the horizontal grid ray march: predicts every cast and compares the results.
`timescale 1ns / 1ps

module ray_march_checker #(
    parameter int BLOCK_SIZE = 64,
    parameter int MAP_SIDE   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgm_in_if           in_ch,
    rgm_out_if          out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [22:0] hit_distance;
        logic        wall_hit;
    } t_cast_result;

    logic         wall_cells [MAP_SIDE*MAP_SIDE];
    logic [6:0]   cols_used;
    logic [6:0]   rows_used;
    logic [7:0]   step_limit;
    t_cast_result pending_hits [$];

    // sign(num) * (|num| * mult << 16) / den, truncated in magnitude
    function automatic longint scaled_quot(longint num, longint mult, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag * mult) <<< 16) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint floor_root(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic t_cast_result march_ray(logic [11:0] pxu, logic [11:0] pyu,
                                               logic signed [6:0] pzs,
                                               logic signed [15:0] dxs,
                                               logic signed [15:0] dys,
                                               logic signed [15:0] dzs);
        t_cast_result r;
        longint px, py, pz, dx, dy, dz, ady, rem, dfirst;
        longint x, y, z, sx, sz, ystep, half, xlim, zz, mx, my, ox, oy, ax, ay, d;
        int steps;
        px = pxu; py = pyu; pz = pzs; dx = dxs; dy = dys; dz = dzs;
        // miss distance never reaches saturation: at most 256*64*256
        r.hit_distance = 23'((longint'(step_limit) + 1) * BLOCK_SIZE * 256);
        r.wall_hit = 1'b0;
        if (dy == 0) return r;
        ady = (dy < 0) ? -dy : dy;
        rem = py % BLOCK_SIZE;
        if (dy > 0) begin
            dfirst = BLOCK_SIZE - rem;
            y = py - rem + BLOCK_SIZE;
            ystep = BLOCK_SIZE;
        end else begin
            dfirst = rem;
            y = py - rem;
            ystep = -BLOCK_SIZE;
        end
        x = px * 65536 + scaled_quot(dx, dfirst, ady);
        z = scaled_quot(dz, dfirst, ady);
        sx = scaled_quot(dx, BLOCK_SIZE, ady);
        sz = scaled_quot(dz, BLOCK_SIZE, ady);
        half = longint'(BLOCK_SIZE / 2) * 65536;
        xlim = longint'(cols_used) * BLOCK_SIZE * 65536;
        for (steps = 0; steps < step_limit; steps++) begin
            zz = z + pz * 65536;
            if (!(x > 0 && x < xlim && zz <= half && zz >= -half)) break;
            mx = (x >>> 16) / BLOCK_SIZE;
            // signed divide truncates toward zero; step one row back for rays going down
            my = y / BLOCK_SIZE - ((dy < 0) ? 1 : 0);
            if (my >= 0 && my < rows_used && my < MAP_SIDE && mx < MAP_SIDE) begin
                if (wall_cells[my*MAP_SIDE + mx]) begin
                    ox = x - px * 65536;
                    ax = ((ox < 0) ? -ox : ox) >>> 8;
                    oy = y - py;
                    ay = ((oy < 0) ? -oy : oy) * 256;
                    d = floor_root(ax * ax + ay * ay);
                    r.hit_distance = (d > 8388607) ? 23'h7FFFFF : 23'(d);
                    r.wall_hit = 1'b1;
                    return r;
                end
            end
            x += sx;
            y += ystep;
            z += sz;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cast_result want;
        if (!i_rst_n) begin
            cols_used  <= rgm_pkg::MAP_WIDTH_RST;
            rows_used  <= rgm_pkg::MAP_HEIGHT_RST;
            step_limit <= rgm_pkg::MAX_STEPS_RST;
            pending_hits.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    rgm_pkg::REG_MAP_WIDTH:  cols_used  <= pwdata[6:0];
                    rgm_pkg::REG_MAP_HEIGHT: rows_used  <= pwdata[6:0];
                    rgm_pkg::REG_MAX_STEPS:  step_limit <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.op == rgm_pkg::OP_WRITE)
                    wall_cells[int'(in_ch.cell_row)*MAP_SIDE + int'(in_ch.cell_col)] =
                        in_ch.cell_is_wall;
                else
                    pending_hits.push_back(march_ray(in_ch.player_x, in_ch.player_y,
                                                     in_ch.player_z, in_ch.ray_dx,
                                                     in_ch.ray_dy, in_ch.ray_dz));
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_hits.size() == 0) begin
                    $error("unexpected result: hit_distance %0d wall_hit %0d",
                           out_ch.hit_distance, out_ch.wall_hit);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pending_hits.pop_front();
                    if (want.hit_distance !== out_ch.hit_distance ||
                        want.wall_hit !== out_ch.wall_hit) begin
                        if (want.hit_distance !== out_ch.hit_distance)
                            $error("hit_distance: expected %0d, got %0d",
                                   want.hit_distance, out_ch.hit_distance);
                        if (want.wall_hit !== out_ch.wall_hit)
                            $error("wall_hit: expected %0d, got %0d",
                                   want.wall_hit, out_ch.wall_hit);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= pending_hits.size();
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the ray march testbench: clock, reset, map load, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT = 20000;
    // loaded corner of the map; width and height stay within it so every probe hits a
    // written cell
    localparam int LOAD_SIDE  = 16;

    typedef struct {
        logic               op;
        logic [5:0]         col;
        logic [5:0]         row;
        logic               wall;
        logic [11:0]        px;
        logic [11:0]        py;
        logic signed [6:0]  pz;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
    } t_ray_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          awaiting;
    int          idle_cycles;
    int          stall_mode;   // 0: receiver always ready, 1: light stalls, 2: heavy stalls
    int          stall_hold = 0;
    bit          sender_gaps;

    rgm_in_if  in_ch();
    rgm_out_if out_ch();

    grid_ray_horizontal_march uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ray_march_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_errors(mismatches), .o_pending(awaiting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hold the result channel at random; mostly short stalls, now and then a long one.
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold   <= stall_hold - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_mode != 0 && $urandom_range(0, 99) == 0) begin
            stall_hold   <= $urandom_range(20, 60);
            out_ch.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 99) < 15) ? 1'b1 :
                                         ($urandom_range(0, 99) < 40);
            endcase
        end
    end

    // End the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (!sender_gaps || pick < 55) return;
        if (pick < 90) repeat ($urandom_range(1, 3)) @(negedge i_clk);
        else repeat ($urandom_range(10, 80)) @(negedge i_clk);
    endtask

    // Present one item at a falling edge and hold it until it is taken.
    task automatic send_ray_item(t_ray_item it);
        in_ch.valid        = 1'b1;
        in_ch.op           = it.op;
        in_ch.cell_col     = it.col;
        in_ch.cell_row     = it.row;
        in_ch.cell_is_wall = it.wall;
        in_ch.player_x     = it.px;
        in_ch.player_y     = it.py;
        in_ch.player_z     = it.pz;
        in_ch.ray_dx       = it.dx;
        in_ch.ray_dy       = it.dy;
        in_ch.ray_dz       = it.dz;
        @(posedge i_clk iff (in_ch.ready));
        @(negedge i_clk);
        if (sender_gaps && $urandom_range(0, 99) >= 55) begin
            in_ch.valid = 1'b0;
            idle_gap();
        end
    endtask

    function automatic t_ray_item cell_write(int c, int r, bit w);
        t_ray_item it;
        it = '{default: '0};
        it.op = rgm_pkg::OP_WRITE;
        it.col = 6'(c);
        it.row = 6'(r);
        it.wall = w;
        it.px = 12'($urandom);
        it.dx = 16'($urandom);
        return it;
    endfunction

    function automatic t_ray_item ray_cast_item(int px, int py, int pz, int dx, int dy,
                                                int dz);
        t_ray_item it;
        it.op = rgm_pkg::OP_CAST;
        it.col = 6'($urandom);
        it.row = 6'($urandom);
        it.wall = 1'($urandom);
        it.px = 12'(px);
        it.py = 12'(py);
        it.pz = 7'(pz);
        it.dx = 16'(dx);
        it.dy = 16'(dy);
        it.dz = 16'(dz);
        return it;
    endfunction

    // Mostly casts near the loaded map with modest height slope; some raw noise.
    function automatic t_ray_item random_item();
        int pick;
        int dy;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return cell_write($urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 99) < 15);
        if (pick < 35)
            return ray_cast_item($urandom_range(0, 4095), $urandom_range(0, 4095),
                                 $urandom_range(0, 64) - 32, $signed(16'($urandom)),
                                 $signed(16'($urandom)), $signed(16'($urandom)));
        dy = $urandom_range(1, 16384);
        if ($urandom_range(0, 1)) dy = -dy;
        if ($urandom_range(0, 49) == 0) dy = 0;
        return ray_cast_item($urandom_range(0, 1100), $urandom_range(0, 1100),
                             $urandom_range(0, 64) - 32, $urandom_range(0, 32768) - 16384,
                             dy, $urandom_range(0, 3000) - 1500);
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain every outstanding cast, then give the block a little slack before reconfiguring.
    task automatic drain();
        in_ch.valid = 1'b0;
        @(negedge i_clk);
        while (awaiting != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    initial begin
        int cfg [6][3];
        int ph;
        int k;
        in_ch.valid = 1'b0;
        in_ch.op = rgm_pkg::OP_WRITE;
        in_ch.cell_col = '0;
        in_ch.cell_row = '0;
        in_ch.cell_is_wall = 1'b0;
        in_ch.player_x = '0;
        in_ch.player_y = '0;
        in_ch.player_z = '0;
        in_ch.ray_dx = '0;
        in_ch.ray_dy = '0;
        in_ch.ray_dz = '0;
        out_ch.ready = 1'b1;
        stall_mode = 0;
        sender_gaps = 1'b0;
        cfg = '{'{16, 16, 32}, '{1, 1, 1}, '{16, 16, 255}, '{12, 10, 100},
                '{16, 16, 0}, '{0, 12, 8}};
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // A zero-dy cast probes nothing and shows the reset step limit.
        send_ray_item(ray_cast_item(100, 100, 0, 4000, 0, 0));
        drain();
        reg_write(rgm_pkg::REG_MAP_WIDTH, LOAD_SIDE);
        reg_write(rgm_pkg::REG_MAP_HEIGHT, LOAD_SIDE);

        // Load the corner in use once so no cast can probe an unwritten cell.
        for (k = 0; k < LOAD_SIDE * LOAD_SIDE; k++)
            send_ray_item(cell_write(k % LOAD_SIDE, k / LOAD_SIDE,
                                     $urandom_range(0, 99) < 12));

        // Directed casts at the field extremes and the listed corner cases.
        send_ray_item(ray_cast_item(100, 100, 0, 4000, 0, 0));          // zero dy
        send_ray_item(ray_cast_item(512, 10, 0, 0, 16384, 0));          // straight up
        send_ray_item(ray_cast_item(512, 1000, 0, 0, -16384, 0));       // straight down
        send_ray_item(ray_cast_item(0, 2000, 0, -32768, 1, 0));         // extreme dx, tiny dy
        send_ray_item(ray_cast_item(4095, 2000, 0, 32767, -1, 0));
        send_ray_item(ray_cast_item(600, 500, 0, 100, -32768, 0));      // most negative dy
        send_ray_item(ray_cast_item(600, 500, 0, 100, 32767, 32767));   // steep height slope
        send_ray_item(ray_cast_item(600, 500, -32, 0, 16384, -16384));
        send_ray_item(ray_cast_item(600, 500, 32, 0, 16384, 16384));
        send_ray_item(ray_cast_item(300, 0, 0, 500, -16384, 0));        // rows below the map
        send_ray_item(ray_cast_item(300, 63, 0, -500, -16384, 0));
        send_ray_item(ray_cast_item(0, 0, 0, 0, 16384, 0));
        send_ray_item(cell_write(63, 63, 1));
        send_ray_item(cell_write(0, 0, 0));
        send_ray_item(ray_cast_item(4064, 3000, 0, 0, 16384, 0));
        send_ray_item(ray_cast_item(10, 10, -32, -16384, -16384, -32768));

        for (ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                drain();
                reg_write(rgm_pkg::REG_MAP_WIDTH, cfg[ph][0]);
                reg_write(rgm_pkg::REG_MAP_HEIGHT, cfg[ph][1]);
                reg_write(rgm_pkg::REG_MAX_STEPS, cfg[ph][2]);
            end
            stall_mode  = ph % 3;
            sender_gaps = (ph % 2 == 1) || ph == 4;
            for (k = 0; k < 65; k++) begin
                send_ray_item(random_item());
                // pause the sender once mid-phase until every cast has answered
                if (k == 30) drain();
            end
        end

        drain();
        repeat (300) @(negedge i_clk);
        if (mismatches == 0 && awaiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
